### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, switched off while rst_n is low
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on clk that also holds through reset
`define ASSERT_ALW(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/ddsw_pkg.sv
`default_nettype none

package ddsw_pkg;

  // field widths
  localparam int CMD_W   = 16;
  localparam int SPEED_W = 8;
  localparam int TIME_W  = 32;
  localparam int STEP_W  = 7;
  localparam int DUTY_W  = 10;
  localparam int MAG_W   = 7;
  localparam int OP_W    = 2;
  localparam int CFG_A_W = 1;

  // item kinds
  localparam logic [OP_W-1:0] OP_CMD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_TIMEOUT = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_SLEW    = 1'd1;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;
  localparam logic [STEP_W-1:0] SLEW_RESET    = 7'd3;

  localparam logic signed [CMD_W-1:0]   CMD_LIMIT   = 16'sd100;
  localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 8'sd100;

  // pwm scaling: duty = floor(mag * (2^PWM_BITS-1) / 100), done as
  // mag * ceil((2^PWM_BITS-1) * 2^DUTY_SHIFT / 100) >> DUTY_SHIFT
  localparam int PWM_BITS   = 10;
  localparam int DUTY_SHIFT = 16;
  localparam int DUTY_K_W   = PWM_BITS + 10;
  localparam longint unsigned DUTY_K_L =
    (((64'd1 << PWM_BITS) - 64'd1) * (64'd1 << DUTY_SHIFT) + 64'd99) / 64'd100;
  localparam logic [DUTY_K_W-1:0] DUTY_K = DUTY_K_W'(DUTY_K_L);
  localparam int PROD_W = DUTY_SHIFT + DUTY_W + PWM_BITS;

  // per-beat control for one motor lane
  typedef struct packed {
    logic load;     // take a new clamped target
    logic clr_tgt;  // watchdog expired, target to zero
    logic slew;     // move speed toward target
    logic stop;     // emergency stop
  } lane_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/ddsw_lane.sv
`default_nettype none

module ddsw_lane (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire ddsw_pkg::lane_ctl_t                     ctl,
  input  wire logic signed [ddsw_pkg::CMD_W-1:0]       cmd,
  input  wire logic [ddsw_pkg::STEP_W-1:0]             step,
  output logic signed [ddsw_pkg::SPEED_W-1:0]          speed_nxt
);
  import ddsw_pkg::*;

  `include "assert_macros.svh"

  logic signed [SPEED_W-1:0] tgt_r, tgt_nxt, speed_r;
  logic signed [SPEED_W-1:0] cmd_clamp, tgt_eff, slewed;
  logic signed [SPEED_W:0]   diff, stepv, up, dn;

  // clamp the command to the speed range
  always_comb begin
    if (cmd > CMD_LIMIT) begin
      cmd_clamp = SPEED_LIMIT;
    end else if (cmd < -CMD_LIMIT) begin
      cmd_clamp = -SPEED_LIMIT;
    end else begin
      cmd_clamp = cmd[SPEED_W-1:0];
    end
  end

  // target after a watchdog clear, used by the slew
  assign tgt_eff = ctl.clr_tgt ? '0 : tgt_r;

  // limited step toward the target
  always_comb begin
    diff  = {tgt_eff[SPEED_W-1], tgt_eff} - {speed_r[SPEED_W-1], speed_r};
    stepv = {2'b00, step};
    up    = {speed_r[SPEED_W-1], speed_r} + stepv;
    dn    = {speed_r[SPEED_W-1], speed_r} - stepv;
    if (diff <= stepv && diff >= -stepv) begin
      slewed = tgt_eff;
    end else if (diff > 0) begin
      slewed = up[SPEED_W-1:0];
    end else begin
      slewed = dn[SPEED_W-1:0];
    end
  end

  // next target and speed
  always_comb begin
    tgt_nxt   = tgt_r;
    speed_nxt = speed_r;
    if (ctl.stop) begin
      tgt_nxt   = '0;
      speed_nxt = '0;
    end else if (ctl.load) begin
      tgt_nxt = cmd_clamp;
    end else if (ctl.slew) begin
      tgt_nxt   = tgt_eff;
      speed_nxt = slewed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r   <= '0;
      speed_r <= '0;
    end else begin
      tgt_r   <= tgt_nxt;
      speed_r <= speed_nxt;
    end
  end

  `ASSERT_RST(a_speed_range, (speed_r <= SPEED_LIMIT && speed_r >= -SPEED_LIMIT), "lane speed out of range")
  `ASSERT_RST(a_stop_zero, ctl.stop |=> (speed_r == '0 && tgt_r == '0), "stop did not zero lane")

endmodule

`default_nettype wire

### hw/rtl/ddsw_duty.sv
`default_nettype none

module ddsw_duty (
  input  wire logic signed [ddsw_pkg::SPEED_W-1:0] speed,
  output logic [ddsw_pkg::DUTY_W-1:0]              duty,
  output logic                                     dir
);
  import ddsw_pkg::*;

  logic [SPEED_W-1:0] mag;
  logic [PROD_W-1:0]  prod;

  // magnitude and direction
  assign dir = speed[SPEED_W-1];
  assign mag = dir ? SPEED_W'(-speed) : SPEED_W'(speed);

  // scale by reciprocal constant, keep the low duty bits of the quotient
  assign prod = PROD_W'(mag[MAG_W-1:0]) * PROD_W'(DUTY_K);
  assign duty = prod[DUTY_SHIFT +: DUTY_W];

endmodule

`default_nettype wire

### hw/rtl/diff_drive_slew_watchdog.sv
`default_nettype none

// Two-motor speed controller with slew limiting and a command watchdog.
// One beat is accepted per clock while in_tready is high, a sustained rate of
// one item per cycle set by the combinational lane update (clamp, watchdog
// compare, slew add). Each beat gives one result beat: the lane registers
// update at the accepting edge and the result is registered into the output
// register, or into the skid entry while that is held. A two-entry output
// buffer lets the input keep accepting while one result waits on out_tready.
// Items kind 0 load targets, 1 tick (watchdog then slew), 2 emergency stop;
// kind 3 changes nothing. Configuration writes (index 0 timeout in us, index
// 1 slew step) are taken at any edge with cfg_we high and should be made idle.
module diff_drive_slew_watchdog (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // left_cmd, right_cmd, now_us
  input  wire logic [1:0]  in_tuser,   // op
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // actual_left, actual_right, duty_left,
                                       // dir_left, duty_right, dir_right,
                                       // watchdog_fired, zero pad
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [ddsw_pkg::CFG_A_W-1:0] cfg_addr,
  input  wire logic [31:0] cfg_wdata
);
  import ddsw_pkg::*;

  `include "assert_macros.svh"

  typedef struct packed {
    logic                      fired;
    logic signed [SPEED_W-1:0] right;
    logic signed [SPEED_W-1:0] left;
  } res_t;

  logic [TIME_W-1:0] timeout_r, last_cmd_r, last_cmd_nxt, age;
  logic [STEP_W-1:0] step_r;
  logic              acc, fired;
  logic [OP_W-1:0]   op;
  logic signed [CMD_W-1:0] left_cmd, right_cmd;
  logic [TIME_W-1:0] now_us;
  lane_ctl_t         ctl_l, ctl_r;
  res_t              res_new;
  logic signed [SPEED_W-1:0] spd_l_nxt, spd_r_nxt;

  logic ov_r, sv_r, pop;
  res_t od_r, sd_r;

  logic [DUTY_W-1:0] duty_l, duty_r;
  logic              dir_l, dir_r;

  // unpack the input beat
  assign op        = in_tuser;
  assign left_cmd  = in_tdata[15:0];
  assign right_cmd = in_tdata[31:16];
  assign now_us    = in_tdata[63:32];
  assign acc       = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      step_r    <= SLEW_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        REG_SLEW:    step_r    <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // watchdog: modular age against timeout
  assign age   = now_us - last_cmd_r;
  assign fired = acc && (op == OP_TICK) && (age >= timeout_r);

  always_comb begin
    last_cmd_nxt = last_cmd_r;
    if (acc && (op == OP_CMD || op == OP_STOP)) begin
      last_cmd_nxt = now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cmd_r <= '0;
    end else begin
      last_cmd_r <= last_cmd_nxt;
    end
  end

  // lane control, same for both motors
  always_comb begin
    ctl_l.load    = acc && (op == OP_CMD);
    ctl_l.clr_tgt = fired;
    ctl_l.slew    = acc && (op == OP_TICK);
    ctl_l.stop    = acc && (op == OP_STOP);
    ctl_r         = ctl_l;
  end

  ddsw_lane u_lane_l (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_l),
    .cmd       (left_cmd),
    .step      (step_r),
    .speed_nxt (spd_l_nxt)
  );

  ddsw_lane u_lane_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r),
    .cmd       (right_cmd),
    .step      (step_r),
    .speed_nxt (spd_r_nxt)
  );

  // merge lane results into one beat
  assign res_new = '{fired: fired, right: spd_r_nxt, left: spd_l_nxt};

  // output register plus skid entry
  assign in_tready = !sv_r;
  assign pop       = ov_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || pop) begin
      if (sv_r) begin
        ov_r <= 1'b1;
        sv_r <= 1'b0;
      end else begin
        ov_r <= acc;
      end
    end else if (acc) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || pop) begin
      if (sv_r) begin
        od_r <= sd_r;
      end else if (acc) begin
        od_r <= res_new;
      end
    end else if (acc) begin
      sd_r <= res_new;
    end
  end

  // pwm duty and direction from the held speeds
  ddsw_duty u_duty_l (
    .speed (od_r.left),
    .duty  (duty_l),
    .dir   (dir_l)
  );

  ddsw_duty u_duty_r (
    .speed (od_r.right),
    .duty  (duty_r),
    .dir   (dir_r)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, od_r.fired, dir_r, duty_r, dir_l, duty_l, od_r.right, od_r.left};

  `ASSERT_RST(a_skid_order, sv_r |-> ov_r, "skid entry held without output entry")
  `ASSERT_RST(a_cmd_stamp, (acc && op == OP_CMD) |=> (last_cmd_r == $past(now_us)), "command time not stamped")
  `ASSERT_RST(a_fire_tick, fired |-> (acc && op == OP_TICK), "watchdog fired outside a tick")

endmodule

`default_nettype wire

### tb/ddsw_result_checker.sv
`timescale 1ns / 1ps

module ddsw_result_checker
  import ddsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [63:0]        in_tdata,   // left_cmd, right_cmd, now_us
  input  logic [1:0]         in_tuser,   // op
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [39:0]        out_tdata,  // actual_left, actual_right, duty_left,
                                         // dir_left, duty_right, dir_right,
                                         // watchdog_fired, zero pad
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  // result beat layout, msb first
  typedef struct packed {
    logic       pad;
    logic       fired;
    logic       dir_r;
    logic [9:0] duty_r;
    logic       dir_l;
    logic [9:0] duty_l;
    logic [7:0] act_r;
    logic [7:0] act_l;
  } drive_result_t;

  drive_result_t drive_expected_q[$];

  // shadow of the controller state and registers
  logic signed [7:0] tgt_l, tgt_r, spd_l, spd_r;
  logic [31:0]       cmd_stamp;
  logic [31:0]       timeout_lim;
  logic [6:0]        step_lim;

  function automatic logic signed [7:0] clamp_pct(logic signed [15:0] v);
    if (v > 16'sd100) return 8'sd100;
    if (v < -16'sd100) return -8'sd100;
    return v[7:0];
  endfunction

  // move toward the target by at most one step, land on it when close
  function automatic logic signed [7:0] slew_to(logic signed [7:0] cur,
                                                logic signed [7:0] tgt,
                                                logic [6:0] step);
    int d, s, n;
    d = int'(tgt) - int'(cur);
    s = int'(step);
    if (d <= s && d >= -s) return tgt;
    n = (d > 0) ? int'(cur) + s : int'(cur) - s;
    return n[7:0];
  endfunction

  function automatic logic [9:0] duty_of_pct(logic signed [7:0] sp);
    int mag;
    mag = (sp < 0) ? -int'(sp) : int'(sp);
    return 10'((mag * ((1 << PWM_BITS) - 1)) / 100);
  endfunction

  // one item against the shadow state, returns its result beat
  function automatic drive_result_t predict_drive(logic [1:0] op, logic [63:0] d);
    drive_result_t r;
    logic [31:0]   now, age;
    r   = '0;
    now = d[63:32];
    case (op)
      OP_CMD: begin
        tgt_l     = clamp_pct(d[15:0]);
        tgt_r     = clamp_pct(d[31:16]);
        cmd_stamp = now;
      end
      OP_TICK: begin
        age = now - cmd_stamp;
        if (age >= timeout_lim) begin
          tgt_l   = '0;
          tgt_r   = '0;
          r.fired = 1'b1;
        end
        spd_l = slew_to(spd_l, tgt_l, step_lim);
        spd_r = slew_to(spd_r, tgt_r, step_lim);
      end
      OP_STOP: begin
        tgt_l     = '0;
        tgt_r     = '0;
        spd_l     = '0;
        spd_r     = '0;
        cmd_stamp = now;
      end
      default: ;
    endcase
    r.act_l  = spd_l;
    r.act_r  = spd_r;
    r.duty_l = duty_of_pct(spd_l);
    r.dir_l  = spd_l < 0;
    r.duty_r = duty_of_pct(spd_r);
    r.dir_r  = spd_r < 0;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // watch config, input and result channels
  always @(posedge clk) begin
    drive_result_t want, got;
    if (!rst_n) begin
      tgt_l       = '0;
      tgt_r       = '0;
      spd_l       = '0;
      spd_r       = '0;
      cmd_stamp   = '0;
      timeout_lim = TIMEOUT_RESET;
      step_lim    = SLEW_RESET;
      drive_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TIMEOUT: timeout_lim = cfg_wdata;
          REG_SLEW:    step_lim    = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        drive_expected_q.push_back(predict_drive(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (drive_expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none got %h",
                   $time, out_tdata);
        end else begin
          want = drive_expected_q.pop_front();
          check_field("actual_left", int'($signed(want.act_l)), int'($signed(got.act_l)));
          check_field("actual_right", int'($signed(want.act_r)), int'($signed(got.act_r)));
          check_field("duty_left", int'(want.duty_l), int'(got.duty_l));
          check_field("dir_left", int'(want.dir_l), int'(got.dir_l));
          check_field("duty_right", int'(want.duty_r), int'(got.duty_r));
          check_field("dir_right", int'(want.dir_r), int'(got.dir_r));
          check_field("watchdog_fired", int'(want.fired), int'(got.fired));
        end
      end
    end
    pending = drive_expected_q.size();
  end

endmodule

### tb/diff_drive_slew_watchdog_tb.sv
`timescale 1ns / 1ps

module diff_drive_slew_watchdog_tb;
  import ddsw_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // unused kind, changes nothing
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 88;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata   = '0;  // left_cmd, right_cmd, now_us
  logic [1:0]         in_tuser   = '0;  // op
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [39:0]        out_tdata;        // actual_left, actual_right, duty_left,
                                        // dir_left, duty_right, dir_right,
                                        // watchdog_fired, zero pad
  logic               cfg_we     = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr   = '0;
  logic [31:0]        cfg_wdata  = '0;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          stall_left  = 0;
  bit          no_gaps     = 1'b0;
  logic [31:0] clock_us    = '0;
  logic [31:0] last_stamp  = '0;
  logic [31:0] cur_timeout = TIMEOUT_RESET;

  diff_drive_slew_watchdog DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ddsw_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall after each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready)
        stall_left = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one input beat, with a random gap ahead of it
  task automatic send_beat(input logic [1:0] op, input logic [15:0] lcmd,
                           input logic [15:0] rcmd, input logic [31:0] now);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {now, rcmd, lcmd};
    do @(posedge clk); while (!in_tready);
    if (op == OP_CMD || op == OP_STOP) last_stamp = now;
  endtask

  // drain all results before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [31:0] val);
    cfg_addr  <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_TIMEOUT) cur_timeout = val;
  endtask

  function automatic logic [15:0] pick_speed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom());
    if (r < 22) begin
      case ($urandom_range(0, 6))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return -16'sd101;
        3: return 16'sd101;
        4: return -16'sd100;
        5: return 16'sd100;
        default: return '0;
      endcase
    end
    return 16'($signed($urandom_range(0, 240)) - 120);
  endfunction

  // time moves mostly forward in small steps, sometimes lands on the timeout edge
  task automatic advance_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)      clock_us = clock_us + $urandom_range(0, 400);
    else if (r < 80) clock_us = clock_us + $urandom_range(0, 5000);
    else if (r < 92) clock_us = last_stamp + cur_timeout + $urandom_range(0, 2) - 1;
    else             clock_us = $urandom();
  endtask

  task automatic random_beat();
    int r;
    logic [1:0] op;
    r = $urandom_range(0, 99);
    if (r < 20)      op = OP_CMD;
    else if (r < 88) op = OP_TICK;
    else if (r < 94) op = OP_STOP;
    else             op = OP_NONE;
    advance_clock();
    send_beat(op, pick_speed(), pick_speed(), clock_us);
  endtask

  task automatic random_config();
    int r;
    case ($urandom_range(0, 5))
      0: write_reg(REG_TIMEOUT, 32'd0);
      1: write_reg(REG_TIMEOUT, 32'hffff_ffff);
      2: write_reg(REG_TIMEOUT, TIMEOUT_RESET);
      3: write_reg(REG_TIMEOUT, $urandom_range(50, 3000));
      4: write_reg(REG_TIMEOUT, $urandom());
      default: write_reg(REG_TIMEOUT, $urandom_range(3000, 20000));
    endcase
    r = $urandom_range(0, 9);
    case (r)
      0: write_reg(REG_SLEW, 32'd0);
      1: write_reg(REG_SLEW, 32'd127);
      2: write_reg(REG_SLEW, 32'd1);
      3: write_reg(REG_SLEW, 32'd100);
      default: write_reg(REG_SLEW, $urandom_range(1, 20));
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: watchdog edge, clamping, unused kind, time wrap
    send_beat(OP_TICK, '0, '0, 32'd0);
    send_beat(OP_CMD, 16'h7fff, 16'h8000, 32'd100);
    send_beat(OP_TICK, '0, '0, 32'd200);
    send_beat(OP_CMD, 16'sd100, -16'sd100, 32'd300);
    send_beat(OP_CMD, 16'sd101, -16'sd101, 32'd400);
    send_beat(OP_NONE, 16'hffff, 16'hffff, 32'hffff_ffff);
    send_beat(OP_TICK, '0, '0, 32'd400 + 32'd299999);
    send_beat(OP_TICK, '0, '0, 32'd400 + 32'd300000);
    send_beat(OP_CMD, -16'sd7, 16'sd5, 32'hffff_ff00);
    send_beat(OP_TICK, '0, '0, 32'h0000_0100);
    send_beat(OP_STOP, 16'h5555, 16'haaaa, 32'h1234_5678);
    send_beat(OP_CMD, 16'h8001, 16'h00ff, 32'h1234_5679);

    // full step, watchdog never fires
    settle();
    write_reg(REG_SLEW, 32'd100);
    write_reg(REG_TIMEOUT, 32'hffff_ffff);
    send_beat(OP_TICK, '0, '0, 32'haaaa_aaaa);
    send_beat(OP_CMD, 16'sd40, -16'sd70, 32'h5555_5555);
    send_beat(OP_TICK, '0, '0, 32'h5555_5556);
    send_beat(OP_TICK, '0, '0, 32'h5555_5557);

    // zero step holds speeds away from target
    settle();
    write_reg(REG_SLEW, 32'd0);
    send_beat(OP_CMD, -16'sd100, 16'sd100, 32'h5555_5558);
    send_beat(OP_TICK, '0, '0, 32'h5555_5559);

    // zero timeout fires on every tick
    settle();
    write_reg(REG_TIMEOUT, 32'd0);
    send_beat(OP_TICK, '0, '0, 32'h5555_555a);

    // largest step, no overshoot
    settle();
    write_reg(REG_SLEW, 32'd127);
    send_beat(OP_TICK, '0, '0, 32'h5555_555b);
    settle();
    write_reg(REG_TIMEOUT, 32'd1000);
    send_beat(OP_CMD, -16'sd100, 16'sd100, 32'd5000);
    send_beat(OP_TICK, '0, '0, 32'd5001);
    send_beat(OP_CMD, 16'sd100, -16'sd100, 32'd5002);
    send_beat(OP_TICK, '0, '0, 32'd5003);
    send_beat(OP_STOP, '0, '0, 32'd5004);
    clock_us = 32'd5004;

    // random phases, each with its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      random_config();
      no_gaps = (ph % 3 == 2);
      repeat (PHASE_ITEMS) random_beat();
    end

    settle();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ddsw_pkg.sv
hw/rtl/ddsw_lane.sv
hw/rtl/ddsw_duty.sv
hw/rtl/diff_drive_slew_watchdog.sv
tb/ddsw_result_checker.sv
tb/diff_drive_slew_watchdog_tb.sv
